// ===== sv/bmprpd_pkg.sv =====
package bmprpd_pkg;

    // Field widths fixed by the port list
    localparam int COLOR_W     = 24;
    localparam int OUT_W       = 12;
    localparam int DIM_W       = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int DEPTH_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Depth mode codes; the unused code decodes as 24 bpp
    localparam logic [DEPTH_W-1:0] DEPTH_4BPP  = 2'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 2'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_24BPP = 2'd2;

    // Input item kinds
    localparam logic ACTION_PALETTE = 1'b0;
    localparam logic ACTION_PIXEL   = 1'b1;

endpackage

// ===== sv/bmprpd_palette.sv =====
module bmprpd_palette
    import bmprpd_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [COLOR_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr_a,
    input  logic [AW-1:0]      i_rd_addr_b,
    output logic [COLOR_W-1:0] o_rd_data_a,
    output logic [COLOR_W-1:0] o_rd_data_b
);

    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic [COLOR_W-1:0] r_rd_a;
    logic [COLOR_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read strobe
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== sv/bmp_row_pixel_decoder.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_action, i_data_byte, i_palette_index,
//                                                i_palette_color
// output    out        o_out_valid / i_out_stall o_pixel_color, o_out_row, o_out_col,
//                                                o_last_of_item, o_last_of_image
// config    in         i_cfg_wr_en               i_cfg_index, i_cfg_wr_data
//
// One byte transfers per cycle at 8 and 24 bpp while the output does not stall; a 4 bpp
// byte that yields two pixels holds the input until its second pixel leaves the pixel
// stage, as both pixels are held in the single pixel stage. A pixel passes the pixel stage
// (with the palette read), then the output register; a second pixel follows the first.
// Reset is synchronous, active low: counters clear, 24 bpp, 1x1; palette undefined till written.
// A stall on the output holds the output register, then the pixel stage, then the input.
module bmp_row_pixel_decoder
    import bmprpd_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]       i_cfg_wr_data,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_action,
    input  logic [7:0]             i_data_byte,
    input  logic [7:0]             i_palette_index,
    input  logic [COLOR_W-1:0]     i_palette_color,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COLOR_W-1:0]     o_pixel_color,
    output logic [OUT_W-1:0]       o_out_row,
    output logic [OUT_W-1:0]       o_out_col,
    output logic                   o_last_of_item,
    output logic                   o_last_of_image
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int SW  = $clog2(3 * MAX_WIDTH + 4);
    localparam int PAW = $clog2(PALETTE_DEPTH);
    localparam int CW  = (WW > DIM_W) ? WW : DIM_W;
    localparam int CHW = (HW > DIM_W) ? HW : DIM_W;

    // Pixel stage contents: up to two pixels from one byte
    typedef struct packed {
        logic               two;
        logic               from_pal;
        logic               zero_hi;
        logic [COLOR_W-1:0] rgb;
        logic [OUT_W-1:0]   row;
        logic [OUT_W-1:0]   col;
        logic               last_item0;
        logic               last_img0;
        logic               last_img1;
    } t_s1_meta;

    // Configuration registers
    logic [DEPTH_W-1:0] r_depth_mode;
    logic [DIM_W-1:0]   r_image_width;
    logic [DIM_W-1:0]   r_image_height;

    // Row walk state
    logic [SW-1:0] r_byte_in_row, n_byte_in_row;
    logic [WW-1:0] r_pixel_col,   n_pixel_col;
    logic [HW-1:0] r_file_row,    n_file_row;
    logic [15:0]   r_partial,     n_partial;
    logic [1:0]    r_byte_phase,  n_byte_phase;

    // Pixel stage and output register
    logic     r_s1_valid;
    logic     r_s1_idx;
    t_s1_meta r_s1;
    t_s1_meta n_s1;
    logic     n_s1_load;

    logic               r_out_valid;
    logic [COLOR_W-1:0] r_pixel_color;
    logic [OUT_W-1:0]   r_out_row;
    logic [OUT_W-1:0]   r_out_col;
    logic               r_last_of_item;
    logic               r_last_of_image;

    // Derived geometry
    logic [CW-1:0]  width_ext;
    logic [CHW-1:0] height_ext;
    logic [WW-1:0]  w_clamp;
    logic [HW-1:0]  h_clamp;
    logic [SW-1:0]  w_sw;
    logic [SW-1:0]  data_bytes;
    logic [SW-1:0]  stride;
    logic [HW-1:0]  fr;
    logic [WW-1:0]  col_p1;
    logic           second;

    logic in_xfer;
    logic pix_xfer;
    logic out_ready;
    logic s1_last;
    logic s1_free;

    logic [PAW-1:0]     pal_wr_addr;
    logic               pal_wr_en;
    logic [PAW-1:0]     pal_rd_addr_hi;
    logic [PAW-1:0]     pal_rd_addr_lo;
    logic [COLOR_W-1:0] pal_rd_hi;
    logic [COLOR_W-1:0] pal_rd_lo;
    logic [COLOR_W-1:0] s1_color;

    // ------------------------------------------------------------------
    // Handshake: the pixel stage frees when empty or when its last pixel
    // moves to the output register this cycle.
    // ------------------------------------------------------------------
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_last    = !r_s1.two || r_s1_idx;
    assign s1_free    = !r_s1_valid || (out_ready && s1_last);
    assign o_in_stall = !s1_free;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign pix_xfer   = in_xfer && (i_action == ACTION_PIXEL);

    // ------------------------------------------------------------------
    // Geometry: clamp size, padded row length in bytes
    // ------------------------------------------------------------------
    assign width_ext  = CW'(r_image_width);
    assign height_ext = CHW'(r_image_height);

    always_comb begin
        if (width_ext == '0) begin
            w_clamp = WW'(1);
        end else if (width_ext > CW'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(width_ext);
        end
        if (height_ext == '0) begin
            h_clamp = HW'(1);
        end else if (height_ext > CHW'(MAX_HEIGHT)) begin
            h_clamp = HW'(MAX_HEIGHT);
        end else begin
            h_clamp = HW'(height_ext);
        end
    end

    assign w_sw = SW'(w_clamp);

    always_comb begin
        case (r_depth_mode)
            DEPTH_4BPP: data_bytes = (w_sw + SW'(1)) >> 1;
            DEPTH_8BPP: data_bytes = w_sw;
            default:    data_bytes = w_sw + (w_sw << 1);
        endcase
    end

    assign stride = (data_bytes + SW'(3)) & ~SW'(3);

    // ------------------------------------------------------------------
    // Byte decode: next row walk state and pixel stage contents
    // ------------------------------------------------------------------
    assign fr     = (r_file_row >= h_clamp) ? '0 : r_file_row;
    assign col_p1 = r_pixel_col + WW'(1);
    assign second = col_p1 < w_clamp;

    always_comb begin
        n_byte_in_row = r_byte_in_row;
        n_pixel_col   = r_pixel_col;
        n_file_row    = r_file_row;
        n_partial     = r_partial;
        n_byte_phase  = r_byte_phase;
        n_s1_load     = 1'b0;

        n_s1.two        = 1'b0;
        n_s1.from_pal   = 1'b1;
        n_s1.zero_hi    = 1'b0;
        n_s1.rgb        = {r_partial[7:0], r_partial[15:8], i_data_byte};
        n_s1.row        = OUT_W'(h_clamp - HW'(1) - fr);
        n_s1.col        = OUT_W'(r_pixel_col);
        n_s1.last_item0 = 1'b1;
        n_s1.last_img0  = (fr == h_clamp - HW'(1)) && (r_pixel_col == w_clamp - WW'(1));
        n_s1.last_img1  = (fr == h_clamp - HW'(1)) && (col_p1 == w_clamp - WW'(1));

        if (pix_xfer) begin
            n_file_row = fr;
            if (r_pixel_col < w_clamp) begin
                case (r_depth_mode)
                    DEPTH_4BPP: begin
                        n_s1_load       = 1'b1;
                        n_s1.two        = second;
                        n_s1.last_item0 = !second;
                        n_pixel_col     = second ? (r_pixel_col + WW'(2)) : col_p1;
                    end
                    DEPTH_8BPP: begin
                        n_s1_load    = 1'b1;
                        n_s1.zero_hi = {1'b0, i_data_byte} >= 9'(PALETTE_DEPTH);
                        n_pixel_col  = col_p1;
                    end
                    default: begin
                        n_s1.from_pal = 1'b0;
                        case (r_byte_phase)
                            2'd0: begin
                                n_partial    = {8'd0, i_data_byte};
                                n_byte_phase = 2'd1;
                            end
                            2'd1: begin
                                n_partial    = {i_data_byte, r_partial[7:0]};
                                n_byte_phase = 2'd2;
                            end
                            default: begin
                                n_s1_load    = 1'b1;
                                n_pixel_col  = col_p1;
                                n_byte_phase = 2'd0;
                            end
                        endcase
                    end
                endcase
            end

            // Count every byte, padding included; wrap at the padded row length
            n_byte_in_row = r_byte_in_row + SW'(1);
            if (n_byte_in_row >= stride) begin
                n_byte_in_row = '0;
                n_pixel_col   = '0;
                n_byte_phase  = 2'd0;
                n_partial     = '0;
                n_file_row    = ((fr + HW'(1)) >= h_clamp) ? '0 : (fr + HW'(1));
            end
        end
    end

    // ------------------------------------------------------------------
    // Palette: write on palette transfers; read the byte, or both nibbles at 4 bpp, on pixel load
    // ------------------------------------------------------------------
    assign pal_wr_addr = PAW'(i_palette_index);
    assign pal_wr_en   = in_xfer && (i_action == ACTION_PALETTE)
                         && ({1'b0, i_palette_index} < 9'(PALETTE_DEPTH));
    assign pal_rd_addr_hi = (r_depth_mode == DEPTH_4BPP) ? PAW'({4'd0, i_data_byte[7:4]})
                                                         : PAW'(i_data_byte);
    assign pal_rd_addr_lo = PAW'({4'd0, i_data_byte[3:0]});

    bmprpd_palette #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (PAW)
    ) u_palette (
        .i_clk       (i_clk),
        .i_wr_en     (pal_wr_en),
        .i_wr_addr   (pal_wr_addr),
        .i_wr_data   (i_palette_color),
        .i_rd_en     (n_s1_load),
        .i_rd_addr_a (pal_rd_addr_hi),
        .i_rd_addr_b (pal_rd_addr_lo),
        .o_rd_data_a (pal_rd_hi),
        .o_rd_data_b (pal_rd_lo)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode   <= DEPTH_24BPP;
            r_image_width  <= DIM_W'(1);
            r_image_height <= DIM_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DEPTH_MODE:   r_depth_mode   <= i_cfg_wr_data[DEPTH_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wr_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_in_row <= '0;
            r_pixel_col   <= '0;
            r_file_row    <= '0;
            r_partial     <= '0;
            r_byte_phase  <= 2'd0;
        end else begin
            r_byte_in_row <= n_byte_in_row;
            r_pixel_col   <= n_pixel_col;
            r_file_row    <= n_file_row;
            r_partial     <= n_partial;
            r_byte_phase  <= n_byte_phase;
        end
    end

    // Pixel stage: load on a producing byte, advance one pixel per output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_idx   <= 1'b0;
        end else if (n_s1_load) begin
            r_s1_valid <= 1'b1;
            r_s1_idx   <= 1'b0;
        end else if (r_s1_valid && out_ready) begin
            r_s1_valid <= !s1_last;
            r_s1_idx   <= !s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_s1_load) begin
            r_s1 <= n_s1;
        end
    end

    always_comb begin
        if (r_s1_idx) begin
            s1_color = pal_rd_lo;
        end else if (!r_s1.from_pal) begin
            s1_color = r_s1.rgb;
        end else if (r_s1.zero_hi) begin
            s1_color = '0;
        end else begin
            s1_color = pal_rd_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_pixel_color   <= s1_color;
            r_out_row       <= r_s1.row;
            r_out_col       <= r_s1_idx ? (r_s1.col + OUT_W'(1)) : r_s1.col;
            r_last_of_item  <= r_s1_idx ? 1'b1 : r_s1.last_item0;
            r_last_of_image <= r_s1_idx ? r_s1.last_img1 : r_s1.last_img0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_color   = r_pixel_color;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_last_of_item  = r_last_of_item;
    assign o_last_of_image = r_last_of_image;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while pixel stage and output are both held");

    a_second_pixel_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !r_last_of_item) |=> r_out_valid)
        else $error("second pixel of a byte did not follow the first");

    a_image_end_ends_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last_of_image) |-> r_last_of_item)
        else $error("last pixel of image is not last of its byte");

    a_idx_only_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_idx |-> (r_s1_valid && r_s1.two))
        else $error("pixel stage points at a second pixel that does not exist");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import bmprpd_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int PAL_ENTRIES   = 256;
    // Two pipeline stages plus the second pixel of a 4 bpp byte; round up well.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 870;
    localparam int MAX_REPORTS   = 40;

    // Codes the package leaves unnamed: spare register index, spare depth code.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED  = 2'd3;
    localparam logic [DEPTH_W-1:0]     DEPTH_SPARE = 2'd3;

    typedef struct packed {
        logic               action;
        logic [7:0]         data_byte;
        logic [7:0]         palette_index;
        logic [COLOR_W-1:0] palette_color;
    } t_byte_item;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [OUT_W-1:0]   row;
        logic [OUT_W-1:0]   col;
        logic               last_item;
        logic               last_image;
    } t_pixel;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_TYPED} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [DIM_W-1:0]       reg_data;
        t_byte_item             item;
        t_pixel                 px;
    } t_dir_row;

    // DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]       i_cfg_wr_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_action = 1'b0;
    logic [7:0]             i_data_byte = '0;
    logic [7:0]             i_palette_index = '0;
    logic [COLOR_W-1:0]     i_palette_color = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [COLOR_W-1:0]     o_pixel_color;
    logic [OUT_W-1:0]       o_out_row;
    logic [OUT_W-1:0]       o_out_col;
    logic                   o_last_of_item;
    logic                   o_last_of_image;

    // Shadow of the decoder: registers, palette and row/column position
    logic [DEPTH_W-1:0] cfg_depth;
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;
    logic [COLOR_W-1:0] palette_shadow [PAL_ENTRIES];
    int unsigned        row_byte_cnt;
    int unsigned        col_cnt;
    int unsigned        file_row_cnt;
    logic [15:0]        rgb_partial;
    int unsigned        rgb_phase;

    t_pixel pixel_q [$];
    t_pixel head_px;
    t_dir_row dir_rows [$];

    int  err_count      = 0;
    int  items_sent     = 0;
    int  palette_writes = 0;
    int  pixels_checked = 0;
    int  image_ends     = 0;
    int  cfg_writes     = 0;
    int  rand_items     = 0;
    int  pixels_by_mode [4] = '{0, 0, 0, 0};
    int  stall_left     = 0;
    bit  no_idle        = 1'b0;

    bmp_row_pixel_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_color   (o_pixel_color),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_item  (o_last_of_item),
        .o_last_of_image (o_last_of_image)
    );

    always #2 i_clk = ~i_clk;

    // Idle length shared by sender and receiver: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Build one pixel at the current row/column position.
    function automatic t_pixel make_pixel(logic [COLOR_W-1:0] c, int unsigned w,
                                          int unsigned h, bit last_item);
        t_pixel      px;
        int unsigned flipped;
        flipped       = h - 1 - file_row_cnt;
        px.color      = c;
        px.row        = flipped[OUT_W-1:0];
        px.col        = col_cnt[OUT_W-1:0];
        px.last_item  = last_item;
        px.last_image = (file_row_cnt == h - 1) && (col_cnt == w - 1);
        return px;
    endfunction

    // Decode one transferred byte item; return up to two pixels in output order.
    task automatic decode_byte(input t_byte_item it, output int n,
                               output t_pixel p0, output t_pixel p1);
        int unsigned w, h, bpp, stride;
        bit          second;
        logic [7:0]  b;
        n  = 0;
        p0 = '0;
        p1 = '0;
        b  = it.data_byte;
        w  = clamp_dim(cfg_width, MAX_W);
        h  = clamp_dim(cfg_height, MAX_H);
        bpp = (cfg_depth == DEPTH_4BPP) ? 4 : ((cfg_depth == DEPTH_8BPP) ? 8 : 24);
        stride = (((w * bpp + 7) / 8) + 3) & ~32'd3;
        if (it.action == ACTION_PALETTE) begin
            palette_shadow[it.palette_index] = it.palette_color;
        end else begin
            // Height shrunk under the current row: restart the image.
            if (file_row_cnt >= h) file_row_cnt = 0;
            if (col_cnt < w) begin
                if (bpp == 4) begin
                    // High nibble is the left pixel; drop the right one past the row end.
                    second = (col_cnt + 1 < w);
                    p0 = make_pixel(palette_shadow[{4'h0, b[7:4]}], w, h, !second);
                    col_cnt++;
                    n = 1;
                    if (second) begin
                        p1 = make_pixel(palette_shadow[{4'h0, b[3:0]}], w, h, 1'b1);
                        col_cnt++;
                        n = 2;
                    end
                end else if (bpp == 8) begin
                    p0 = make_pixel(palette_shadow[b], w, h, 1'b1);
                    col_cnt++;
                    n = 1;
                end else begin
                    // File order is blue, green, red.
                    case (rgb_phase)
                        0: begin
                            rgb_partial = {8'h00, b};
                            rgb_phase   = 1;
                        end
                        1: begin
                            rgb_partial = {b, rgb_partial[7:0]};
                            rgb_phase   = 2;
                        end
                        default: begin
                            p0 = make_pixel({rgb_partial[7:0], rgb_partial[15:8], b},
                                            w, h, 1'b1);
                            col_cnt++;
                            n = 1;
                            rgb_phase = 0;
                        end
                    endcase
                end
            end
            // Count padding too; wrap the row at the padded stride.
            row_byte_cnt++;
            if (row_byte_cnt >= stride) begin
                row_byte_cnt = 0;
                col_cnt      = 0;
                rgb_phase    = 0;
                rgb_partial  = '0;
                file_row_cnt = (file_row_cnt + 1 >= h) ? 0 : file_row_cnt + 1;
            end
        end
    endtask

    // Present one item, hold it until the transfer, then queue its pixels.
    task automatic send_item(input t_byte_item it, input bit typed, input t_pixel typed_px);
        int     n;
        int     gap;
        t_pixel p0, p1;
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_action        = it.action;
        i_data_byte     = it.data_byte;
        i_palette_index = it.palette_index;
        i_palette_color = it.palette_color;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(it, n, p0, p1);
        if (typed) begin
            if (n != 1) begin
                err_count++;
                $display("%0t ERROR typed row expects 1 pixel, decode gives %0d", $time, n);
            end
            pixel_q.push_back(typed_px);
        end else begin
            if (n > 0) pixel_q.push_back(p0);
            if (n > 1) pixel_q.push_back(p1);
        end
        pixels_by_mode[cfg_depth] += n;
        items_sent++;
        if (it.action == ACTION_PALETTE) palette_writes++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Wait for every queued pixel, bounded; drop leftovers as failures.
    task automatic drain_pixels();
        int waited;
        waited = 0;
        while (pixel_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pixel_q.size() != 0) begin
            err_count++;
            $display("%0t ERROR %0d expected pixels never came, first: color %06h row %0d col %0d",
                     $time, pixel_q.size(), pixel_q[0].color, pixel_q[0].row, pixel_q[0].col);
            pixel_q.delete();
        end
    endtask

    // Drop valid, let the pipeline empty, then give it the latency margin.
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_index   = idx;
        i_cfg_wr_data = data;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        case (idx)
            CFG_DEPTH_MODE:   cfg_depth  = data[DEPTH_W-1:0];
            CFG_IMAGE_WIDTH:  cfg_width  = data;
            CFG_IMAGE_HEIGHT: cfg_height = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Mostly small sizes; now and then zero, one, the maximum, above it, or anything.
    function automatic logic [DIM_W-1:0] pick_size(int small_max);
        if ($urandom_range(0, 99) < 75) return DIM_W'($urandom_range(1, small_max));
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return DIM_W'(1);
            2:       return DIM_W'(MAX_W);
            3:       return '1;
            default: return DIM_W'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic random_settings();
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_DEPTH_MODE, ($urandom_range(0, 9) == 0) ?
                      DIM_W'(DEPTH_SPARE) : DIM_W'($urandom_range(0, 2)));
        if ($urandom_range(0, 1) == 1) write_reg(CFG_IMAGE_WIDTH, pick_size(9));
        if ($urandom_range(0, 1) == 1) write_reg(CFG_IMAGE_HEIGHT, pick_size(4));
        if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, DIM_W'($urandom));
    endtask

    function automatic t_byte_item random_item();
        t_byte_item it;
        it.action        = ($urandom_range(0, 11) == 0) ? ACTION_PALETTE : ACTION_PIXEL;
        it.data_byte     = 8'($urandom);
        it.palette_index = 8'($urandom);
        it.palette_color = COLOR_W'($urandom);
        return it;
    endfunction

    function automatic t_dir_row pix_row(logic [7:0] b);
        t_dir_row r;
        r.kind     = ROW_ITEM;
        r.reg_idx  = '0;
        r.reg_data = '0;
        r.item     = '{action: ACTION_PIXEL, data_byte: b, palette_index: '0,
                       palette_color: '0};
        r.px       = '0;
        return r;
    endfunction

    function automatic t_dir_row pal_row(logic [7:0] idx, logic [COLOR_W-1:0] c);
        t_dir_row r;
        r = pix_row(8'h00);
        r.item.action        = ACTION_PALETTE;
        r.item.palette_index = idx;
        r.item.palette_color = c;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [DIM_W-1:0] d);
        t_dir_row r;
        r = pix_row(8'h00);
        r.kind     = ROW_CFG;
        r.reg_idx  = idx;
        r.reg_data = d;
        return r;
    endfunction

    function automatic t_dir_row typed_row(logic [7:0] b, logic [COLOR_W-1:0] c,
                                           int row, int col, bit li, bit lim);
        t_dir_row r;
        r = pix_row(b);
        r.kind = ROW_TYPED;
        r.px   = '{color: c, row: OUT_W'(row), col: OUT_W'(col), last_item: li,
                   last_image: lim};
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [COLOR_W-1:0] want,
                                 input logic [COLOR_W-1:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t ERROR %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Receiver: raise stall in bursts of random length, changed at the falling edge.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                stall_left  = pick_gap();
                i_out_stall = (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Check every pixel transfer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixel_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t ERROR unexpected pixel: expected none, actual color %06h row %0d col %0d",
                             $time, o_pixel_color, o_out_row, o_out_col);
            end else begin
                head_px = pixel_q.pop_front();
                compare_field("pixel_color", head_px.color, o_pixel_color);
                compare_field("out_row", COLOR_W'(head_px.row), COLOR_W'(o_out_row));
                compare_field("out_col", COLOR_W'(head_px.col), COLOR_W'(o_out_col));
                compare_field("last_of_item", COLOR_W'(head_px.last_item),
                              COLOR_W'(o_last_of_item));
                compare_field("last_of_image", COLOR_W'(head_px.last_image),
                              COLOR_W'(o_last_of_image));
                pixels_checked++;
                if (o_last_of_image) image_ends++;
            end
        end
    end

    // Bail out if the run hangs on a handshake.
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        // Shadow state after reset: 24 bpp, 1x1, all counters clear.
        cfg_depth    = DEPTH_24BPP;
        cfg_width    = DIM_W'(1);
        cfg_height   = DIM_W'(1);
        row_byte_cnt = 0;
        col_cnt      = 0;
        file_row_cnt = 0;
        rgb_partial  = '0;
        rgb_phase    = 0;

        // Directed table. At reset a 1x1 image at 24 bpp is 3 bytes plus one pad.
        dir_rows.push_back(pix_row(8'h00));
        dir_rows.push_back(pix_row(8'h00));
        dir_rows.push_back(typed_row(8'hFF, 24'h0000FF, 0, 0, 1'b1, 1'b1));
        dir_rows.push_back(pix_row(8'hAA));
        // Load only entries 00, 0F and FF; the 55 bytes below are row padding and read no entry.
        dir_rows.push_back(pal_row(8'h00, 24'hFFFFFF));
        dir_rows.push_back(pal_row(8'h0F, 24'h000000));
        dir_rows.push_back(pal_row(8'hFF, 24'h81FF01));
        // 4 bpp, 3 wide, 2 high: 2 data bytes and 2 pad bytes per row.
        dir_rows.push_back(cfg_row(CFG_DEPTH_MODE, DIM_W'(DEPTH_4BPP)));
        dir_rows.push_back(cfg_row(CFG_IMAGE_WIDTH, DIM_W'(3)));
        dir_rows.push_back(cfg_row(CFG_IMAGE_HEIGHT, DIM_W'(2)));
        dir_rows.push_back(pix_row(8'hF0));
        // Right nibble falls past the row end and is dropped.
        dir_rows.push_back(typed_row(8'h0F, 24'hFFFFFF, 1, 2, 1'b1, 1'b0));
        dir_rows.push_back(pix_row(8'h55));
        dir_rows.push_back(pix_row(8'h55));
        dir_rows.push_back(pix_row(8'hFF));
        dir_rows.push_back(typed_row(8'h00, 24'hFFFFFF, 0, 2, 1'b1, 1'b1));
        dir_rows.push_back(pix_row(8'h55));
        dir_rows.push_back(pix_row(8'h55));
        // 8 bpp at the largest size: first file row is image row 4095.
        dir_rows.push_back(cfg_row(CFG_DEPTH_MODE, DIM_W'(DEPTH_8BPP)));
        dir_rows.push_back(cfg_row(CFG_IMAGE_WIDTH, DIM_W'(MAX_W)));
        dir_rows.push_back(cfg_row(CFG_IMAGE_HEIGHT, DIM_W'(MAX_H)));
        dir_rows.push_back(typed_row(8'hFF, 24'h81FF01, 4095, 0, 1'b1, 1'b0));
        dir_rows.push_back(pix_row(8'h00));
        // Spare depth code decodes as 24 bpp; gather one pixel mid-row.
        dir_rows.push_back(cfg_row(CFG_DEPTH_MODE, DIM_W'(DEPTH_SPARE)));
        dir_rows.push_back(pix_row(8'h12));
        dir_rows.push_back(pix_row(8'h34));
        dir_rows.push_back(pix_row(8'h56));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            case (dir_rows[k].kind)
                ROW_CFG: begin
                    quiesce();
                    write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_data);
                end
                ROW_TYPED: send_item(dir_rows[k].item, 1'b1, dir_rows[k].px);
                default:   send_item(dir_rows[k].item, 1'b0, '0);
            endcase
        end

        // Fill the whole palette so no later lookup hits an unwritten entry.
        for (int e = 0; e < PAL_ENTRIES; e++)
            send_item('{action: ACTION_PALETTE, data_byte: 8'($urandom),
                        palette_index: 8'(e), palette_color: COLOR_W'($urandom)},
                      1'b0, '0);

        // Random phases: settle, change some registers, then a burst of bytes.
        while (rand_items < RANDOM_ITEMS) begin
            quiesce();
            no_idle = ($urandom_range(0, 4) == 0);
            random_settings();
            repeat ($urandom_range(10, 90)) begin
                send_item(random_item(), 1'b0, '0);
                rand_items++;
                // Now and then hold the sender until all pixels are out.
                if ($urandom_range(0, 199) == 0) quiesce();
            end
        end
        no_idle = 1'b0;
        quiesce();

        $display("summary: %0d byte transfers (%0d palette writes), %0d pixels checked, %0d image ends",
                 items_sent, palette_writes, pixels_checked, image_ends);
        $display("summary: %0d register writes; pixels at 4/8/24 bpp and spare code: %0d/%0d/%0d/%0d",
                 cfg_writes, pixels_by_mode[0], pixels_by_mode[1], pixels_by_mode[2],
                 pixels_by_mode[3]);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
